FILE: design/hal_pkg.sv
// hal_pkg: shared constants for the hashed address lock table
// op codes, field widths and stream packing widths
// no dependencies
package hal_pkg;

    // request op codes
    localparam logic [1:0] OP_LOCK   = 2'd0;
    localparam logic [1:0] OP_UNLOCK = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // request field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 12;
    localparam int LEN_W   = 16;
    localparam int OWNER_W = 32;

    // result field widths
    localparam int BLK_W     = 6;
    localparam int CNT_OUT_W = 7;

    // line count dividend: length + offset + line size - 1 stays below 2^17
    localparam int LDIV_W = 17;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

endpackage

FILE: design/hal_cdiv.sv
// hal_cdiv: divide an unsigned value by a fixed divisor
// power-of-two divisors by shift and mask, others by reciprocal multiplication
// no dependencies
module hal_cdiv #(
    parameter int DIVISOR = 64,
    parameter int DW      = 17
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [DW-1:0]                dividend,
    output logic                         done,
    output logic [DW-1:0]                quot,
    output logic [$clog2(DIVISOR)-1:0]   rem
);

    localparam int RW      = $clog2(DIVISOR);
    localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

    generate
        if (IS_POW2) begin : g_shift
            logic          done_reg;
            logic [DW-1:0] quot_reg;
            logic [RW-1:0] rem_reg;

            // done is start registered
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            // shift and mask
            always_ff @(posedge aclk) begin
                if (start) begin
                    quot_reg <= dividend >> RW;
                    rem_reg  <= dividend[RW-1:0];
                end
            end

            assign done = done_reg;
            assign quot = quot_reg;
            assign rem  = rem_reg;
        end else begin : g_recip
            // reciprocal rounded up; exact for every DW-bit dividend
            localparam int              SH      = DW + RW;
            localparam int              MW      = DW + 2;
            localparam longint unsigned RECIP   =
                ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
            localparam logic [MW-1:0]   RECIP_C = MW'(RECIP);
            localparam logic [DW-1:0]   DIV_C   = DW'(DIVISOR);

            logic             stage_reg;
            logic             done_reg;
            logic [DW-1:0]    dvd_reg;
            logic [DW-1:0]    quot_reg;
            logic [RW-1:0]    rem_reg;
            logic [DW+MW-1:0] prod;
            logic [DW-1:0]    qd;
            logic [DW-1:0]    rem_full;

            // quotient by multiply and shift, remainder by back-multiply
            assign prod     = (DW + MW)'(dividend) * (DW + MW)'(RECIP_C);
            assign qd       = quot_reg * DIV_C;
            assign rem_full = dvd_reg - qd;

            // quotient registered on start; remainder and done registered on stage_reg
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end else begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    dvd_reg  <= dividend;
                    quot_reg <= DW'(prod >> SH);
                end
                if (stage_reg) begin
                    rem_reg <= rem_full[RW-1:0];
                end
            end

            assign done = done_reg;
            assign quot = quot_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

FILE: design/hal_mem.sv
// hal_mem: slot owner memory, one write and one registered read port
// per-entry valid bits make unwritten or cleared slots read as free
// depends on hal_pkg
module hal_mem
    import hal_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clr_all,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [OWNER_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [OWNER_W-1:0] rd_data
);

    logic [OWNER_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;
    logic [OWNER_W-1:0] rd_data_reg;

    // valid bits: cleared at once by reset or clear all
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clr_all) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // storage array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: design/hashed_address_lock_table_unit.sv
// hashed_address_lock_table_unit: top level of the address lock table
// depends on hal_pkg, hal_cdiv, hal_mem
//
// channel  dir  width  fields (lowest bit first)
// s_axis   in   64     op[1:0] address[13:2] length[29:14] owner[61:30]
// m_axis   out  16     busy_res[0] blocking_slot[6:1] slot_count[13:7]
//
// one request at a time; a lock over n slots does a memory read scan, then one
// write per slot unless the scan finds a slot holding the request's owner; unlock
// only writes; a non-power-of-two line size or slot count divides by reciprocal
// multiplication, with the remainder registered after the quotient
// reset clears all slots at once through per-slot valid bits
// a new request is taken while the previous result waits on m_tready
module hashed_address_lock_table_unit
    import hal_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int LINE_BYTES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // op, address, length, owner
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // busy_res, blocking_slot, slot_count
);

    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int CW  = $clog2(SLOT_COUNT + 1);
    localparam int LRW = $clog2(LINE_BYTES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVA  = 3'd1;
    localparam logic [2:0] ST_DIVB  = 3'd2;
    localparam logic [2:0] ST_PREP  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // request fields
    logic [OP_W-1:0]    s_op;
    logic [ADDR_W-1:0]  s_address;
    logic [LEN_W-1:0]   s_length;
    logic [OWNER_W-1:0] s_owner;
    logic               s_accept;

    assign s_op      = s_tdata[1:0];
    assign s_address = s_tdata[13:2];
    assign s_length  = s_tdata[29:14];
    assign s_owner   = s_tdata[61:30];
    assign s_accept  = s_tvalid && s_tready;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [OP_W-1:0]    op_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [SW-1:0]      base_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      wrap_reg;
    logic [CW-1:0]      k_reg;
    logic               lines_ok_reg;
    logic               base_ok_reg;
    logic               pend_reg;
    logic [SW-1:0]      pend_slot_reg;
    logic               busy_reg;
    logic [SW-1:0]      blk_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // line divider, shared between address split and line count
    logic              lb_start;
    logic [LDIV_W-1:0] lb_dividend;
    logic              lb_done;
    logic [LDIV_W-1:0] lb_quot;
    logic [LRW-1:0]    lb_rem;

    // slot divider for the base slot
    logic              sc_start;
    logic              sc_done;
    logic [SW-1:0]     sc_rem;

    logic              is_range;
    logic [CW-1:0]     count_cap;
    logic [CW:0]       base_plus;
    logic [CW:0]       slot_sum;
    logic [SW-1:0]     slot_k;
    logic              issue;
    logic              hit;
    logic              out_free;

    // memory port
    logic               mem_clr;
    logic               mem_wr_en;
    logic [OWNER_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [OWNER_W-1:0] mem_rd_data;

    assign is_range = (s_op == OP_LOCK) || (s_op == OP_UNLOCK);

    // divider operand selection
    assign lb_start = (s_accept && is_range) || (state_reg == ST_DIVA && lb_done);
    assign lb_dividend = (state_reg == ST_IDLE)
        ? LDIV_W'(s_address)
        : LDIV_W'(length_reg) + LDIV_W'(lb_rem) + LDIV_W'(LINE_BYTES - 1);
    assign sc_start = (state_reg == ST_DIVA) && lb_done;

    hal_cdiv #(
        .DIVISOR (LINE_BYTES),
        .DW      (LDIV_W)
    ) u_line_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lb_start),
        .dividend (lb_dividend),
        .done     (lb_done),
        .quot     (lb_quot),
        .rem      (lb_rem)
    );

    hal_cdiv #(
        .DIVISOR (SLOT_COUNT),
        .DW      (ADDR_W)
    ) u_slot_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sc_start),
        .dividend (lb_quot[ADDR_W-1:0]),
        .done     (sc_done),
        .quot     (),
        .rem      (sc_rem)
    );

    // slot count saturates at the table size
    assign count_cap = (lb_quot > LDIV_W'(SLOT_COUNT))
        ? CW'(SLOT_COUNT) : lb_quot[CW-1:0];

    // wrapped slots first, then base upward
    assign base_plus = (CW + 1)'(base_reg) + (CW + 1)'(count_reg);
    assign slot_sum  = (CW + 1)'(base_reg) + (CW + 1)'(k_reg) - (CW + 1)'(wrap_reg);
    assign slot_k    = (k_reg < wrap_reg) ? k_reg[SW-1:0] : slot_sum[SW-1:0];

    // scan control
    assign issue    = (k_reg != count_reg);
    assign hit      = pend_reg && (mem_rd_data == owner_reg);
    assign out_free = !m_valid_reg || m_tready;

    assign mem_clr     = s_accept && (s_op == OP_CLEAR);
    assign mem_rd_en   = (state_reg == ST_SCAN) && issue;
    assign mem_wr_en   = (state_reg == ST_WRITE);
    assign mem_wr_data = (op_reg == OP_LOCK) ? owner_reg : '0;

    hal_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (SW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr_all (mem_clr),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_k),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (slot_k),
        .rd_data (mem_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = is_range ? ST_DIVA : ST_DONE;
                end
            end
            ST_DIVA: begin
                if (lb_done) begin
                    state_next = ST_DIVB;
                end
            end
            ST_DIVB: begin
                if ((lines_ok_reg || lb_done) && (base_ok_reg || sc_done)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else if (op_reg == OP_LOCK) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_DONE;
                end else if (!issue && !pend_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (k_reg + 1'b1 == count_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lines_ok_reg <= 1'b0;
            base_ok_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIVA) begin
                lines_ok_reg <= 1'b0;
                base_ok_reg  <= 1'b0;
            end else if (state_reg == ST_DIVB) begin
                if (lb_done) begin
                    lines_ok_reg <= 1'b1;
                end
                if (sc_done) begin
                    base_ok_reg <= 1'b1;
                end
            end
            pend_reg <= mem_rd_en;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_reg     <= s_op;
                    owner_reg  <= (s_owner == '0) ? OWNER_W'(1) : s_owner;
                    length_reg <= s_length;
                    busy_reg   <= 1'b0;
                    blk_reg    <= '0;
                    count_reg  <= (s_op == OP_CLEAR) ? CW'(SLOT_COUNT) : '0;
                end
            end
            ST_DIVB: begin
                if (lb_done) begin
                    count_reg <= count_cap;
                end
                if (sc_done) begin
                    base_reg <= sc_rem;
                end
            end
            ST_PREP: begin
                k_reg    <= '0;
                wrap_reg <= (base_plus > (CW + 1)'(SLOT_COUNT))
                    ? CW'(base_plus - (CW + 1)'(SLOT_COUNT)) : '0;
            end
            ST_SCAN: begin
                if (issue) begin
                    k_reg         <= k_reg + 1'b1;
                    pend_slot_reg <= slot_k;
                end
                if (hit) begin
                    busy_reg <= 1'b1;
                    blk_reg  <= pend_slot_reg;
                end else if (!issue && !pend_reg) begin
                    k_reg <= '0;
                end
            end
            ST_WRITE: begin
                k_reg <= k_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result register
    logic [SW+BLK_W-1:0]     blk_ext;
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    assign blk_ext = {{BLK_W{1'b0}}, blk_reg};
    assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {2'b00, cnt_ext[CNT_OUT_W-1:0], blk_ext[BLK_W-1:0], busy_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
